### design/ppd_pkg.sv
// Shared types, constants and helpers for the piezo pad hit detector.
package ppd_pkg;

    localparam int PADS          = 6;
    localparam int PAD_W         = 3;
    localparam int PAD_IDX_W     = (PADS > 1) ? $clog2(PADS) : 1;
    localparam int SAMPLE_W      = 10;
    localparam int TIME_W        = 32;
    localparam int DEB_W         = 16;
    localparam int NOTE_W        = 7;
    localparam int VEL_W         = 7;
    localparam int TABLE_ENTRIES = 6;
    localparam int TABLE_W       = TABLE_ENTRIES * NOTE_W;

    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = TABLE_W;

    localparam int S_TDATA_W     = 48;
    localparam int M_TDATA_W     = 16;

    localparam int PROD_W        = SAMPLE_W + VEL_W;
    localparam int DIV_CNT_W     = $clog2(PROD_W);

    localparam int QDEPTH        = 2;
    localparam int QAW           = $clog2(QDEPTH);
    localparam int QCW           = $clog2(QDEPTH + 1);

    localparam logic [VEL_W-1:0]    VEL_MAX        = 7'd127;
    localparam logic [SAMPLE_W-1:0] SENS_RESET     = 10'd120;
    localparam logic [SAMPLE_W-1:0] TRIG_RESET     = 10'd20;
    localparam logic [DEB_W-1:0]    DEBOUNCE_RESET = 16'd50;
    localparam logic [TABLE_W-1:0]  TABLE_RESET    = 42'd2596998882246;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SENSITIVITY   = 2'd0,
        CFG_TRIGGER_LEVEL = 2'd1,
        CFG_DEBOUNCE      = 2'd2,
        CFG_NOTE_TABLE    = 2'd3
    } cfg_addr_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sensitivity;
        logic [SAMPLE_W-1:0] trigger_level;
        logic [DEB_W-1:0]    debounce_ms;
        logic [TABLE_W-1:0]  note_table;
    } cfg_t;

    typedef struct packed {
        logic [PAD_IDX_W-1:0] pad;
        logic [SAMPLE_W-1:0]  sample;
        logic [TIME_W-1:0]    now_ms;
        logic                 hot;
    } item_t;

    function automatic logic [NOTE_W-1:0] note_of(input logic [TABLE_W-1:0] tbl,
                                                  input logic [PAD_IDX_W-1:0] pad);
        logic [NOTE_W-1:0] n;
        n = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (int'(pad) == i) begin
                n = tbl[i*NOTE_W +: NOTE_W];
            end
        end
        return n;
    endfunction

endpackage

### design/piezo_pad_hit_detector.sv
// Top level of the piezo pad hit detector: configuration registers and front/back.
//
//  channel | dir | fields, lowest bit first
//  s_      | in  | tdata: pad[2:0], sample[12:3], now_ms[44:13], zero fill to 48
//  m_      | out | tdata: note[6:0], velocity[13:7], zero fill to 16; tuser: is_note_on;
//          |     | tlast: last
//  cfg_    | in  | cfg_addr: 0 sensitivity, 1 trigger_level, 2 debounce_ms, 3 note_table
//
// A hot sample that updates a pad runs the one-bit-per-cycle restoring divider (17
// steps), then the update state; with no positive span it goes straight to update.
// Quiet or debounced samples end in idle; a release passes the note-on and note-off
// states, each held by result stalls. A two-entry queue lets the front keep taking
// samples meanwhile. Reset is synchronous, active low; clears all pads and output valid.
module piezo_pad_hit_detector (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [ppd_pkg::S_TDATA_W-1:0]    s_tdata,   // pad, sample, now_ms
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ppd_pkg::M_TDATA_W-1:0]    m_tdata,   // note, velocity
    output logic                             m_tuser,   // is_note_on
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [ppd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ppd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    ppd_pkg::cfg_t  cfg_reg;
    logic           q_valid;
    logic           q_ready;
    ppd_pkg::item_t q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sensitivity   <= ppd_pkg::SENS_RESET;
            cfg_reg.trigger_level <= ppd_pkg::TRIG_RESET;
            cfg_reg.debounce_ms   <= ppd_pkg::DEBOUNCE_RESET;
            cfg_reg.note_table    <= ppd_pkg::TABLE_RESET;
        end else if (cfg_we) begin
            case (ppd_pkg::cfg_addr_t'(cfg_addr))
                ppd_pkg::CFG_SENSITIVITY: begin
                    cfg_reg.sensitivity <= cfg_wdata[ppd_pkg::SAMPLE_W-1:0];
                end
                ppd_pkg::CFG_TRIGGER_LEVEL: begin
                    cfg_reg.trigger_level <= cfg_wdata[ppd_pkg::SAMPLE_W-1:0];
                end
                ppd_pkg::CFG_DEBOUNCE: begin
                    cfg_reg.debounce_ms <= cfg_wdata[ppd_pkg::DEB_W-1:0];
                end
                ppd_pkg::CFG_NOTE_TABLE: begin
                    cfg_reg.note_table <= cfg_wdata[ppd_pkg::TABLE_W-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    ppd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    ppd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### design/ppd_front.sv
// Front end: accepts samples, drops bad pad indexes, classifies and queues them.
module ppd_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ppd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  ppd_pkg::cfg_t                  cfg,
    output logic                           q_valid,
    input  logic                           q_ready,
    output ppd_pkg::item_t                 q_item
);

    logic [ppd_pkg::PAD_W-1:0]    pad_in;
    logic [ppd_pkg::SAMPLE_W-1:0] sample_in;
    logic [ppd_pkg::TIME_W-1:0]   now_in;
    logic                         pad_ok;
    logic                         push;
    logic                         pop;
    ppd_pkg::item_t               item_in;

    ppd_pkg::item_t               mem_reg [ppd_pkg::QDEPTH];
    logic [ppd_pkg::QAW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [ppd_pkg::QAW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [ppd_pkg::QCW-1:0]      count_reg, count_next;

    assign pad_in    = s_tdata[ppd_pkg::PAD_W-1:0];
    assign sample_in = s_tdata[ppd_pkg::PAD_W +: ppd_pkg::SAMPLE_W];
    assign now_in    = s_tdata[ppd_pkg::PAD_W + ppd_pkg::SAMPLE_W +: ppd_pkg::TIME_W];

    always_comb begin
        pad_ok         = (int'(pad_in) < ppd_pkg::PADS);
        item_in.pad    = ppd_pkg::PAD_IDX_W'(pad_in);
        item_in.sample = sample_in;
        item_in.now_ms = now_in;
        item_in.hot    = (sample_in >= cfg.trigger_level);
    end

    assign s_tready = (count_reg != ppd_pkg::QCW'(ppd_pkg::QDEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready && pad_ok;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == ppd_pkg::QAW'(ppd_pkg::QDEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == ppd_pkg::QAW'(ppd_pkg::QDEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### design/ppd_back.sv
// Back end: per-pad hit state, serial velocity divider and note message output.
module ppd_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ppd_pkg::cfg_t                  cfg,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  ppd_pkg::item_t                 q_item,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ppd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_ON   = 5'b01000,
        ST_OFF  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [ppd_pkg::PAD_IDX_W-1:0]   pad_reg, pad_next;
    logic [ppd_pkg::TIME_W-1:0]      now_reg, now_next;
    logic [ppd_pkg::PROD_W-1:0]      dvd_reg, dvd_next;
    logic [ppd_pkg::SAMPLE_W-1:0]    rem_reg, rem_next;
    logic [ppd_pkg::PROD_W-1:0]      quo_reg, quo_next;
    logic [ppd_pkg::SAMPLE_W-1:0]    span_reg, span_next;
    logic [ppd_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    logic                            active_reg [ppd_pkg::PADS];
    logic [ppd_pkg::VEL_W-1:0]       peak_reg   [ppd_pkg::PADS];
    logic [ppd_pkg::TIME_W-1:0]      rel_reg    [ppd_pkg::PADS];

    logic                            m_valid_reg, m_valid_next;
    logic                            m_on_reg, m_on_next;
    logic [ppd_pkg::NOTE_W-1:0]      m_note_reg, m_note_next;
    logic [ppd_pkg::VEL_W-1:0]       m_vel_reg, m_vel_next;
    logic                            m_last_reg, m_last_next;

    logic                            q_active;
    logic [ppd_pkg::TIME_W-1:0]      since;
    logic                            deb_ok;
    logic                            span_pos;
    logic [ppd_pkg::SAMPLE_W-1:0]    span;
    logic [ppd_pkg::PROD_W-1:0]      prod;
    logic [ppd_pkg::SAMPLE_W:0]      rem_sh;
    logic [ppd_pkg::VEL_W-1:0]       vel_new;
    logic                            out_free;
    logic                            do_upd;
    logic                            do_clear;

    assign q_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        q_active = active_reg[q_item.pad];
        since    = q_item.now_ms - rel_reg[q_item.pad];
        deb_ok   = (since >= ppd_pkg::TIME_W'(cfg.debounce_ms));
        span_pos = (cfg.sensitivity > cfg.trigger_level);
        span     = cfg.sensitivity - cfg.trigger_level;
        prod     = (ppd_pkg::PROD_W'(q_item.sample) << ppd_pkg::VEL_W)
                 - ppd_pkg::PROD_W'(q_item.sample);
        rem_sh   = {rem_reg, dvd_reg[ppd_pkg::PROD_W-1]};
        vel_new  = (quo_reg > ppd_pkg::PROD_W'(ppd_pkg::VEL_MAX)) ? ppd_pkg::VEL_MAX
                 : quo_reg[ppd_pkg::VEL_W-1:0];
    end

    always_comb begin
        state_next   = state_reg;
        pad_next     = pad_reg;
        now_next     = now_reg;
        dvd_next     = dvd_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        span_next    = span_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_on_next    = m_on_reg;
        m_note_next  = m_note_reg;
        m_vel_next   = m_vel_reg;
        m_last_next  = m_last_reg;
        do_upd       = 1'b0;
        do_clear     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    pad_next = q_item.pad;
                    now_next = q_item.now_ms;
                    if (q_item.hot) begin
                        if (q_active || deb_ok) begin
                            if (span_pos) begin
                                dvd_next   = prod;
                                rem_next   = '0;
                                quo_next   = '0;
                                span_next  = span;
                                cnt_next   = ppd_pkg::DIV_CNT_W'(ppd_pkg::PROD_W - 1);
                                state_next = ST_DIV;
                            end else begin
                                quo_next   = ppd_pkg::PROD_W'(ppd_pkg::VEL_MAX);
                                state_next = ST_UPD;
                            end
                        end
                    end else if (q_active) begin
                        state_next = ST_ON;
                    end
                end
            end
            ST_DIV: begin
                dvd_next = dvd_reg << 1;
                if (rem_sh >= {1'b0, span_reg}) begin
                    rem_next = ppd_pkg::SAMPLE_W'(rem_sh - {1'b0, span_reg});
                    quo_next = {quo_reg[ppd_pkg::PROD_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[ppd_pkg::SAMPLE_W-1:0];
                    quo_next = {quo_reg[ppd_pkg::PROD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                do_upd     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_ON: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_on_next    = 1'b1;
                    m_note_next  = ppd_pkg::note_of(cfg.note_table, pad_reg);
                    m_vel_next   = peak_reg[pad_reg];
                    m_last_next  = 1'b0;
                    state_next   = ST_OFF;
                end
            end
            ST_OFF: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_on_next    = 1'b0;
                    m_vel_next   = '0;
                    m_last_next  = 1'b1;
                    do_clear     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pad_reg    <= pad_next;
        now_reg    <= now_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        span_reg   <= span_next;
        cnt_reg    <= cnt_next;
        m_on_reg   <= m_on_next;
        m_note_reg <= m_note_next;
        m_vel_reg  <= m_vel_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ppd_pkg::PADS; i++) begin
                active_reg[i] <= 1'b0;
                peak_reg[i]   <= '0;
                rel_reg[i]    <= '0;
            end
        end else begin
            for (int i = 0; i < ppd_pkg::PADS; i++) begin
                if (int'(pad_reg) == i) begin
                    if (do_upd) begin
                        active_reg[i] <= 1'b1;
                        if (vel_new > peak_reg[i]) begin
                            peak_reg[i] <= vel_new;
                        end
                    end
                    if (do_clear) begin
                        active_reg[i] <= 1'b0;
                        peak_reg[i]   <= '0;
                        rel_reg[i]    <= now_reg;
                    end
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_on_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = ppd_pkg::M_TDATA_W'({m_vel_reg, m_note_reg});

endmodule

### design/ppd_checker.sv
// Port-level checks for the piezo pad hit detector, bound to the top level.
module ppd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ppd_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != m_tlast))
        else $error("note-on must not end the pair and note-off must");

    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[ppd_pkg::NOTE_W +: ppd_pkg::VEL_W] == '0))
        else $error("note-off with nonzero velocity");

    a_on_then_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser |=> m_tvalid && m_tlast
            && (m_tdata[ppd_pkg::NOTE_W-1:0] == $past(m_tdata[ppd_pkg::NOTE_W-1:0])))
        else $error("note-on transfer not followed by its note-off");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind piezo_pad_hit_detector ppd_checker u_ppd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
